@@ hw/rtl/cartesian_to_polar_converter_top_assert.svh @@
// Assertion macros for the converter RTL, used by c2p_engine.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef CARTESIAN_TO_POLAR_CONVERTER_TOP_ASSERT_SVH
`define CARTESIAN_TO_POLAR_CONVERTER_TOP_ASSERT_SVH

`define C2P_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define C2P_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/c2p_pkg.sv @@
// Shared types, widths and the CORDIC angle table of the converter.
// No dependencies.
package c2p_pkg;

  localparam int SampleW    = 16;
  localparam int SqW        = 2 * SampleW;
  localparam int Guard      = 61 - SampleW - 2;
  localparam int CordicW    = 62;
  localparam int AngleW     = 32;
  localparam int CordicSteps = 31;
  localparam int StepW      = $clog2(CordicSteps);
  localparam int SqrtSteps  = SampleW;
  localparam int PhaseDrop  = AngleW - SampleW;

  typedef struct packed {
    logic signed [SampleW-1:0] re;
    logic signed [SampleW-1:0] im;
  } pair_t;

  typedef struct packed {
    logic        [SampleW-1:0] magnitude;
    logic signed [SampleW-1:0] phase;
  } result_t;

  function automatic logic [AngleW-1:0] atan_angle(input logic [StepW-1:0] idx);
    logic [AngleW-1:0] a;
    case (idx)
      5'd0:  a = 32'h2000_0000;
      5'd1:  a = 32'h12E4_051E;
      5'd2:  a = 32'h09FB_385B;
      5'd3:  a = 32'h0511_11D4;
      5'd4:  a = 32'h028B_0D43;
      5'd5:  a = 32'h0145_D7E1;
      5'd6:  a = 32'h00A2_F61E;
      5'd7:  a = 32'h0051_7C55;
      5'd8:  a = 32'h0028_BE53;
      5'd9:  a = 32'h0014_5F2F;
      5'd10: a = 32'h000A_2F98;
      5'd11: a = 32'h0005_17CC;
      5'd12: a = 32'h0002_8BE6;
      5'd13: a = 32'h0001_45F3;
      5'd14: a = 32'h0000_A2FA;
      5'd15: a = 32'h0000_517D;
      5'd16: a = 32'h0000_28BE;
      5'd17: a = 32'h0000_145F;
      5'd18: a = 32'h0000_0A30;
      5'd19: a = 32'h0000_0518;
      5'd20: a = 32'h0000_028C;
      5'd21: a = 32'h0000_0146;
      5'd22: a = 32'h0000_00A3;
      5'd23: a = 32'h0000_0051;
      5'd24: a = 32'h0000_0029;
      5'd25: a = 32'h0000_0014;
      5'd26: a = 32'h0000_000A;
      5'd27: a = 32'h0000_0005;
      5'd28: a = 32'h0000_0003;
      5'd29: a = 32'h0000_0001;
      5'd30: a = 32'h0000_0001;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

@@ hw/rtl/cartesian_to_polar_converter_top.sv @@
// Cartesian-to-polar converter: front pairing stage, CORDIC/sqrt engine and
// result queue. Depends on c2p_pkg, c2p_front, c2p_engine, c2p_result_q.
//
// Usage:
//   Input side is a queue write port: a component transfers when push is
//   high and full is low. port_i = 0 loads the real part, 1 the imaginary
//   part. Every second transfer, whatever its port, closes a pair.
//   Result side is a queue read port: while empty is low, magnitude_o and
//   phase_o show the oldest result; it transfers when pop is high.
//   The shared engine takes one pair at a time and accepts no new pair
//   until the last result is handed off: it loads the pair, forms the
//   sum of squares, runs 31 CORDIC steps with the 16 square-root steps
//   running alongside, then hands the result off.
//   Components transfer every cycle until two pairs wait for the engine and the first component of a third is held.
//   Reset clears the held components, the pair counter and both queues.
//   A stalled receiver fills the two-entry result queue, then holds the
//   engine, then the pair queue, and finally raises full.
module cartesian_to_polar_converter_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  logic                               port_i,
  input  logic signed [c2p_pkg::SampleW-1:0] sample_value_i,
  output logic                               empty,
  input  logic                               pop,
  output logic        [c2p_pkg::SampleW-1:0] magnitude_o,
  output logic signed [c2p_pkg::SampleW-1:0] phase_o
);
  import c2p_pkg::*;

  logic    pair_valid, pair_ready, res_valid, res_ready;
  pair_t   pair;
  result_t res_eng, res_out;

  c2p_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .port_i         (port_i),
    .sample_value_i (sample_value_i),
    .pair_valid_o   (pair_valid),
    .pair_o         (pair),
    .pair_ready_i   (pair_ready)
  );

  c2p_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pair_valid_i (pair_valid),
    .pair_i       (pair),
    .pair_ready_o (pair_ready),
    .res_valid_o  (res_valid),
    .res_o        (res_eng),
    .res_ready_i  (res_ready)
  );

  c2p_result_q u_result_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_eng),
    .res_ready_o (res_ready),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res_out)
  );

  assign magnitude_o = res_out.magnitude;
  assign phase_o     = res_out.phase;

endmodule

@@ hw/rtl/c2p_front.sv @@
// Front end: accepts components, pairs them and queues pairs for the engine.
// Depends on c2p_pkg.
module c2p_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic                        port_i,
  input  logic signed [c2p_pkg::SampleW-1:0] sample_value_i,
  output logic                        pair_valid_o,
  output c2p_pkg::pair_t              pair_o,
  input  logic                        pair_ready_i
);
  import c2p_pkg::*;

  logic signed [SampleW-1:0] real_q, real_d;
  logic signed [SampleW-1:0] imag_q, imag_d;
  logic                      cnt_q, cnt_d;
  pair_t                     entry_q [2];
  logic                      wr_ptr_q, rd_ptr_q;
  logic [1:0]                fill_q, fill_d;
  logic                      accept, enq, deq;
  pair_t                     new_pair;

  assign full   = cnt_q & (fill_q == 2'd2);
  assign accept = push & ~full;

  always_comb begin
    real_d = real_q;
    imag_d = imag_q;
    cnt_d  = cnt_q;
    if (accept) begin
      if (!port_i) begin
        real_d = sample_value_i;
      end else begin
        imag_d = sample_value_i;
      end
      cnt_d = ~cnt_q;
    end
  end

  assign new_pair.re = real_d;
  assign new_pair.im = imag_d;
  assign enq         = accept & cnt_q;
  assign deq         = pair_valid_o & pair_ready_i;

  always_comb begin
    fill_d = fill_q;
    if (enq && !deq) begin
      fill_d = fill_q + 2'd1;
    end else if (!enq && deq) begin
      fill_d = fill_q - 2'd1;
    end
  end

  assign pair_valid_o = (fill_q != 2'd0);
  assign pair_o       = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_q   <= '0;
      imag_q   <= '0;
      cnt_q    <= 1'b0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      real_q <= real_d;
      imag_q <= imag_d;
      cnt_q  <= cnt_d;
      fill_q <= fill_d;
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q] <= new_pair;
    end
  end

endmodule

@@ hw/rtl/c2p_engine.sv @@
// Back end: iterative CORDIC vectoring for the phase and a digit-by-digit
// square root for the magnitude. Depends on c2p_pkg and the assertion header.
`include "cartesian_to_polar_converter_top_assert.svh"

module c2p_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pair_valid_i,
  input  c2p_pkg::pair_t    pair_i,
  output logic              pair_ready_o,
  output logic              res_valid_o,
  output c2p_pkg::result_t  res_o,
  input  logic              res_ready_i
);
  import c2p_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StSq   = 2'd1;
  localparam logic [1:0] StRun  = 2'd2;
  localparam logic [1:0] StDone = 2'd3;
  localparam logic [StepW-1:0] LastStep = StepW'(CordicSteps - 1);
  localparam logic [SqW-1:0]   SqBitTop = SqW'(1) << (SqW - 2);
  localparam logic [AngleW-1:0] PhaseHalf = AngleW'(1) << (PhaseDrop - 1);

  logic [1:0]                state_q, state_d;
  logic [StepW-1:0]          cnt_q, cnt_d;
  logic signed [CordicW-1:0] x_q, x_d, y_q, y_d;
  logic [AngleW-1:0]         z_q, z_d;
  logic [SqW-1:0]            rem_q, rem_d, root_q, root_d;
  logic signed [SampleW-1:0] im_q, im_d;
  logic                      zero_q, zero_d;

  logic signed [SampleW:0]   re_ext, im_ext, abs_re, y0;
  logic signed [SqW-1:0]     re_sq, im_sq;
  logic signed [CordicW-1:0] xs, ys;
  logic [AngleW-1:0]         step_angle, z_round;
  logic [SqW-1:0]            sqrt_bit;
  logic [SqW:0]              trial;

  assign re_ext = {pair_i.re[SampleW-1], pair_i.re};
  assign im_ext = {pair_i.im[SampleW-1], pair_i.im};
  assign abs_re = pair_i.re[SampleW-1] ? -re_ext : re_ext;
  assign y0     = pair_i.re[SampleW-1] ? -im_ext : im_ext;
  assign re_sq  = pair_i.re * pair_i.re;
  assign im_sq  = im_q * im_q;

  assign xs         = x_q >>> cnt_q;
  assign ys         = y_q >>> cnt_q;
  assign step_angle = atan_angle(cnt_q);
  assign sqrt_bit   = SqBitTop >> {cnt_q, 1'b0};
  assign trial      = {1'b0, root_q} + {1'b0, sqrt_bit};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    rem_d   = rem_q;
    root_d  = root_q;
    im_d    = im_q;
    zero_d  = zero_q;
    case (state_q)
      StIdle: begin
        if (pair_valid_i) begin
          x_d     = {{(CordicW-SampleW-1){1'b0}}, abs_re} << Guard;
          y_d     = {{(CordicW-SampleW-1){y0[SampleW]}}, y0} <<< Guard;
          z_d     = {pair_i.re[SampleW-1], {(AngleW-1){1'b0}}};
          rem_d   = re_sq;
          root_d  = '0;
          im_d    = pair_i.im;
          zero_d  = (pair_i.re == '0) && (pair_i.im == '0);
          cnt_d   = '0;
          state_d = StSq;
        end
      end
      StSq: begin
        rem_d   = rem_q + im_sq;
        state_d = StRun;
      end
      StRun: begin
        if (y_q > 0) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + step_angle;
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - step_angle;
        end
        if (cnt_q < StepW'(SqrtSteps)) begin
          if ({1'b0, rem_q} >= trial) begin
            rem_d  = rem_q - trial[SqW-1:0];
            root_d = (root_q >> 1) + sqrt_bit;
          end else begin
            root_d = root_q >> 1;
          end
        end
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == LastStep) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ready_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  assign pair_ready_o  = (state_q == StIdle);
  assign res_valid_o   = (state_q == StDone);
  assign z_round       = z_q + PhaseHalf;
  assign res_o.magnitude = SampleW'(root_q + SqW'(rem_q > root_q));
  assign res_o.phase     = zero_q ? '0 : z_round[AngleW-1 -: SampleW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    im_q   <= im_d;
    zero_q <= zero_d;
  end

  `C2P_ASSERT_NEXT(a_load_to_sq, pair_valid_i && pair_ready_o, state_q == StSq, "load must square")
  `C2P_ASSERT_NEXT(a_run_ends, (state_q == StRun) && (cnt_q == LastStep), state_q == StDone, "run overran")
  `C2P_ASSERT_NOW(a_sqrt_rem, state_q == StDone, {1'b0, rem_q} <= {root_q, 1'b0}, "sqrt remainder too large")
  `C2P_ASSERT_NOW(a_x_positive, (state_q == StDone) && !zero_q, x_q > 0, "cordic x went negative")

endmodule

@@ hw/rtl/c2p_result_q.sv @@
// Two-entry result queue that presents results to the receiver.
// Depends on c2p_pkg.
module c2p_result_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  c2p_pkg::result_t  res_i,
  output logic              res_ready_o,
  output logic              empty,
  input  logic              pop,
  output c2p_pkg::result_t  res_o
);
  import c2p_pkg::*;

  result_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] fill_q, fill_d;
  logic       enq, deq;

  assign res_ready_o = (fill_q != 2'd2);
  assign empty       = (fill_q == 2'd0);
  assign enq         = res_valid_i & res_ready_o;
  assign deq         = pop & ~empty;
  assign res_o       = entry_q[rd_ptr_q];

  always_comb begin
    fill_d = fill_q;
    if (enq && !deq) begin
      fill_d = fill_q + 2'd1;
    end else if (!enq && deq) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= '0;
    end else begin
      fill_q <= fill_d;
      if (enq) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (deq) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      entry_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

@@ sim/cartesian_to_polar_checker.sv @@
// Scoreboard for the cartesian-to-polar converter: watches both queue ports,
// predicts magnitude and CORDIC phase per closed pair, and compares in order.
// Depends on c2p_pkg for widths, the guard shift and result_t.
`timescale 1ns / 1ps

module cartesian_to_polar_checker
  import c2p_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  input  logic                      full,
  input  logic                      port_i,
  input  logic signed [SampleW-1:0] sample_value_i,
  input  logic                      empty,
  input  logic                      pop,
  input  logic        [SampleW-1:0] magnitude_o,
  input  logic signed [SampleW-1:0] phase_o,
  output int                        fail_count_o,
  output int                        waiting_o
);

  localparam int ReportLimit = 10;

  localparam logic [AngleW-1:0] RotationAngle [CordicSteps] = '{
    32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4, 32'h028B_0D43,
    32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55, 32'h0028_BE53, 32'h0014_5F2F,
    32'h000A_2F98, 32'h0005_17CC, 32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA,
    32'h0000_517D, 32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
    32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051, 32'h0000_0029,
    32'h0000_0014, 32'h0000_000A, 32'h0000_0005, 32'h0000_0003, 32'h0000_0001,
    32'h0000_0001
  };

  logic signed [SampleW-1:0] real_held;
  logic signed [SampleW-1:0] imag_held;
  logic                      second_half;
  result_t                   polar_expected [$];

  function automatic logic [SampleW-1:0] rounded_root(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    if (s > r) r = r + 1;
    return r[SampleW-1:0];
  endfunction

  function automatic logic [SampleW-1:0] vector_angle(longint re, longint im);
    longint            x;
    longint            y;
    longint            xo;
    logic [AngleW-1:0] z;
    logic [AngleW-1:0] rounded;
    if (re == 0 && im == 0) return '0;
    z = '0;
    x = (re < 0 ? -re : re) <<< Guard;
    y = (im < 0 ? -im : im) <<< Guard;
    if (im < 0) y = -y;
    if (re < 0) begin
      y = -y;
      z = 32'h8000_0000;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      xo = x;
      if (y > 0) begin
        x = x + (y >>> i);
        y = y - (xo >>> i);
        z = z + RotationAngle[i];
      end else begin
        x = x - (y >>> i);
        y = y + (xo >>> i);
        z = z - RotationAngle[i];
      end
    end
    rounded = z + (32'd1 << (PhaseDrop - 1));
    return rounded[AngleW-1:PhaseDrop];
  endfunction

  function automatic result_t polar_of(logic signed [SampleW-1:0] re,
                                       logic signed [SampleW-1:0] im);
    result_t r;
    longint  a;
    longint  b;
    a = re;
    b = im;
    r.magnitude = rounded_root(longint'(a * a + b * b));
    r.phase     = vector_angle(a, b);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      real_held    = '0;
      imag_held    = '0;
      second_half  = 1'b0;
      polar_expected.delete();
      fail_count_o = 0;
      waiting_o    = 0;
    end else begin
      if (pop && !empty) begin
        if (polar_expected.size() == 0) begin
          if (fail_count_o < ReportLimit)
            $display("%0t: result with nothing pending: mag %0d phase %0d",
                     $realtime, magnitude_o, phase_o);
          fail_count_o++;
        end else begin
          want = polar_expected.pop_front();
          if (magnitude_o !== want.magnitude || phase_o !== want.phase) begin
            if (fail_count_o < ReportLimit)
              $display("%0t: mismatch: expected mag %0d phase %0d, got mag %0d phase %0d",
                       $realtime, want.magnitude, $signed(want.phase),
                       magnitude_o, phase_o);
            fail_count_o++;
          end
        end
      end
      if (push && !full) begin
        if (port_i == 1'b0) real_held = sample_value_i;
        else imag_held = sample_value_i;
        if (second_half) polar_expected.push_back(polar_of(real_held, imag_held));
        second_half = !second_half;
      end
      waiting_o = polar_expected.size();
    end
  end

endmodule

@@ sim/tb_cartesian_to_polar_converter_top.sv @@
// Testbench top for the cartesian-to-polar converter: clock, reset, component
// stimulus, result draining and verdict. Depends on c2p_pkg, the converter RTL
// and cartesian_to_polar_checker.
`timescale 1ns / 1ps

module tb_cartesian_to_polar_converter_top;
  import c2p_pkg::*;

  localparam int HoldOffCycles = 400;
  localparam int WatchdogLimit = 3000;
  localparam int TailCycles    = 40;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      push;
  logic                      full;
  logic                      port_i;
  logic signed [SampleW-1:0] sample_value_i;
  logic                      empty;
  logic                      pop;
  logic        [SampleW-1:0] magnitude_o;
  logic signed [SampleW-1:0] phase_o;

  int fail_count;
  int waiting_results;
  int stall_cycles;
  bit sender_idle;
  bit receiver_idle;
  bit hold_off_req;

  cartesian_to_polar_converter_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .port_i        (port_i),
    .sample_value_i(sample_value_i),
    .empty         (empty),
    .pop           (pop),
    .magnitude_o   (magnitude_o),
    .phase_o       (phase_o)
  );

  cartesian_to_polar_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .port_i        (port_i),
    .sample_value_i(sample_value_i),
    .empty         (empty),
    .pop           (pop),
    .magnitude_o   (magnitude_o),
    .phase_o       (phase_o),
    .fail_count_o  (fail_count),
    .waiting_o     (waiting_results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    rst_ni <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pop <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      pop <= !receiver_idle || ($urandom_range(99) >= 30);
    end
  end

  task automatic send_component(bit p, logic signed [SampleW-1:0] v);
    int gap;
    if (sender_idle && $urandom_range(99) < 15) begin
      push <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk_i);
    end
    push           <= 1'b1;
    port_i         <= p;
    sample_value_i <= v;
    do @(posedge clk_i); while (full);
  endtask

  task automatic pause_sender();
    push <= 1'b0;
    @(posedge clk_i);
    wait (waiting_results == 0);
    @(posedge clk_i);
  endtask

  function automatic logic signed [SampleW-1:0] pick_sample();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return -32768;
          1: return 32767;
          2: return 0;
          3: return -1;
          default: return 1;
        endcase
      end
      1, 2: return SampleW'($signed(SampleW'($urandom_range(63))) - 32);
      default: return r[SampleW-1:0];
    endcase
  endfunction

  task automatic send_random(int count);
    int  sent;
    bit  first_port;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        first_port = 1'($urandom_range(1));
        send_component(first_port, pick_sample());
        send_component(!first_port, pick_sample());
        sent += 2;
      end else begin
        send_component(1'($urandom_range(1)), pick_sample());
        sent += 1;
      end
    end
  endtask

  initial begin
    push           <= 1'b0;
    port_i         <= 1'b0;
    sample_value_i <= '0;
    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    hold_off_req  = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);

    send_component(0, 0);      send_component(1, 0);
    send_component(0, 32767);  send_component(1, 0);
    send_component(0, -32768); send_component(1, 0);
    send_component(0, 0);      send_component(1, 32767);
    send_component(0, 0);      send_component(1, -32768);
    send_component(0, -32768); send_component(1, -32768);
    send_component(0, 32767);  send_component(1, 32767);
    send_component(0, -32768); send_component(1, 1);
    send_component(0, -32768); send_component(1, -1);
    send_component(1, -1);     send_component(0, 1);
    send_component(0, 100);    send_component(0, -200);
    send_component(1, 5);      send_component(1, -7);

    send_random(200);

    sender_idle  = 1'b0;
    hold_off_req = 1'b1;
    send_random(100);
    pause_sender();

    receiver_idle = 1'b0;
    send_random(150);

    sender_idle   = 1'b1;
    receiver_idle = 1'b1;
    send_random(180);

    pause_sender();
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && waiting_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
